>>> rtl/hsvrgb_pkg.sv
// Shared constants and types for the HSV to RGB converter.
package hsvrgb_pkg;

    localparam int unsigned SECTOR_SPAN = 43;
    localparam logic [7:0]  FULL_LEVEL  = 8'd255;
    localparam logic [2:0]  FRAC_SCALE  = 3'd6;

    // Reciprocal of the sector span: floor(n * RECIP_MUL / 2^RECIP_SHIFT) equals
    // n / 43 for every 16-bit n.
    localparam logic [15:0] RECIP_MUL   = 16'd48771;
    localparam int unsigned RECIP_SHIFT = 21;
    localparam int unsigned QUOT_W      = 32 - RECIP_SHIFT;

    typedef struct packed {
        logic       valid;
        logic [7:0] sector;
        logic [7:0] frac;
    } hsvrgb_div_t;

endpackage

>>> rtl/hsv_to_rgb_8bit.sv
// Top level of the pipelined integer HSV to 8-bit RGB converter.
// One item is taken on every clock in which start is high; busy is always low, since the
// pipeline never stalls. The result passes stages A to D and the output register, then
// appears on red, green and blue, marked by done for exactly one cycle, and a new result can
// follow on every cycle. The pipeline is made of the hue division (two stages), the two rows
// of 8x8 products and the final channel select, each in a register stage of its own.
module hsv_to_rgb_8bit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] hue,
    input  logic [7:0]  saturation,
    input  logic [7:0]  brightness,
    output logic        done,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue
);
    import hsvrgb_pkg::*;

    typedef enum logic [7:0] {
        SECT_RED_YEL  = 8'd0,
        SECT_YEL_GRN  = 8'd1,
        SECT_GRN_CYN  = 8'd2,
        SECT_CYN_BLU  = 8'd3,
        SECT_BLU_MAG  = 8'd4,
        SECT_MAG_RED  = 8'd5
    } sector_t;

    hsvrgb_div_t div_out;

    // Stage A
    logic        vld_a_reg;
    logic [7:0]  sat_a_reg;
    logic [7:0]  val_a_reg;
    logic [15:0] p_prod_a_reg;
    // Stage B
    logic        vld_b_reg;
    logic [7:0]  sat_b_reg;
    logic [7:0]  val_b_reg;
    logic [7:0]  p_b_reg;
    // Stage C
    logic        vld_c_reg;
    logic [7:0]  sat_c_reg;
    logic [7:0]  val_c_reg;
    logic [7:0]  p_c_reg;
    logic [7:0]  sector_c_reg;
    logic [15:0] sf_c_reg;
    logic [15:0] sif_c_reg;
    // Stage D
    logic        vld_d_reg;
    logic [7:0]  sat_d_reg;
    logic [7:0]  val_d_reg;
    logic [7:0]  p_d_reg;
    logic [7:0]  sector_d_reg;
    logic [15:0] q_prod_d_reg;
    logic [15:0] t_prod_d_reg;
    // Output
    logic        done_reg;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;

    logic [7:0]  q_lvl;
    logic [7:0]  t_lvl;
    logic [7:0]  red_next;
    logic [7:0]  green_next;
    logic [7:0]  blue_next;

    hsvrgb_div43 u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .hue      (hue),
        .result   (div_out)
    );

    always_comb
    begin
        q_lvl = q_prod_d_reg[15:8];
        t_lvl = t_prod_d_reg[15:8];
        if (sat_d_reg == 8'd0)
        begin
            red_next   = val_d_reg;
            green_next = val_d_reg;
            blue_next  = val_d_reg;
        end
        else
        begin
            case (sector_d_reg)
                SECT_RED_YEL:
                begin
                    red_next = val_d_reg; green_next = t_lvl;     blue_next = p_d_reg;
                end
                SECT_YEL_GRN:
                begin
                    red_next = q_lvl;     green_next = val_d_reg; blue_next = p_d_reg;
                end
                SECT_GRN_CYN:
                begin
                    red_next = p_d_reg;   green_next = val_d_reg; blue_next = t_lvl;
                end
                SECT_CYN_BLU:
                begin
                    red_next = p_d_reg;   green_next = q_lvl;     blue_next = val_d_reg;
                end
                SECT_BLU_MAG:
                begin
                    red_next = t_lvl;     green_next = p_d_reg;   blue_next = val_d_reg;
                end
                SECT_MAG_RED:
                begin
                    red_next = val_d_reg; green_next = p_d_reg;   blue_next = q_lvl;
                end
                default:
                begin
                    // Hues whose truncated sector number lies beyond the six sectors come out black.
                    red_next = 8'd0;      green_next = 8'd0;      blue_next = 8'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
            vld_d_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            vld_a_reg <= start;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg & div_out.valid;
            vld_d_reg <= vld_c_reg;
            done_reg  <= vld_d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sat_a_reg    <= saturation;
        val_a_reg    <= brightness;
        p_prod_a_reg <= 16'(brightness) * 16'(FULL_LEVEL - saturation);

        sat_b_reg    <= sat_a_reg;
        val_b_reg    <= val_a_reg;
        p_b_reg      <= p_prod_a_reg[15:8];

        sat_c_reg    <= sat_b_reg;
        val_c_reg    <= val_b_reg;
        p_c_reg      <= p_b_reg;
        sector_c_reg <= div_out.sector;
        sf_c_reg     <= 16'(sat_b_reg) * 16'(div_out.frac);
        sif_c_reg    <= 16'(sat_b_reg) * 16'(FULL_LEVEL - div_out.frac);

        sat_d_reg    <= sat_c_reg;
        val_d_reg    <= val_c_reg;
        p_d_reg      <= p_c_reg;
        sector_d_reg <= sector_c_reg;
        q_prod_d_reg <= 16'(val_c_reg) * 16'(FULL_LEVEL - sf_c_reg[15:8]);
        t_prod_d_reg <= 16'(val_c_reg) * 16'(FULL_LEVEL - sif_c_reg[15:8]);

        red_reg      <= red_next;
        green_reg    <= green_next;
        blue_reg     <= blue_next;
    end

    assign busy  = 1'b0;
    assign done  = done_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

>>> rtl/hsvrgb_div43.sv
// Two-stage pipelined division of the hue by the sector span.
module hsvrgb_div43 (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [15:0]               hue,
    output hsvrgb_pkg::hsvrgb_div_t   result
);
    import hsvrgb_pkg::*;

    logic                vld1_reg;
    logic [31:0]         prod_reg;
    logic [15:0]         hue1_reg;
    logic                vld2_reg;
    logic [7:0]          sector_reg;
    logic [7:0]          frac_reg;

    logic [QUOT_W-1:0]   quot;
    logic [15:0]         quot_times_span;
    logic [15:0]         rem_full;
    logic [7:0]          frac_next;

    always_comb
    begin
        quot            = prod_reg[31 -: QUOT_W];
        quot_times_span = 16'(quot) * 16'(SECTOR_SPAN);
        rem_full        = hue1_reg - quot_times_span;
        // The remainder is below 43, so six times it fits in eight bits.
        frac_next       = 8'(rem_full[5:0]) * 8'(FRAC_SCALE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= 32'(hue) * 32'(RECIP_MUL);
        hue1_reg   <= hue;
        sector_reg <= quot[7:0];
        frac_reg   <= frac_next;
    end

    assign result.valid  = vld2_reg;
    assign result.sector = sector_reg;
    assign result.frac   = frac_reg;

endmodule
